// ===== rtl/kptl_pkg.sv =====
// ----------------------------------------------------------------------------
// kptl_pkg
// Types and constants shared by the key tap / long-press detector.
// ----------------------------------------------------------------------------
package kptl_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int IDLE_CODE_WIDTH = 8;
    localparam int TAP_WIDTH       = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDLE_CODE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_TICKS   = 2'd2;

    localparam logic [CFG_DATA_WIDTH-1:0] LONG_TICKS_RESET = 16'd100;
    localparam logic [CFG_DATA_WIDTH-1:0] GAP_TICKS_RESET  = 16'd30;

    localparam logic [TAP_WIDTH-1:0] TAP_MAX = '1;

    typedef enum logic [1:0] {
        PS_IDLE = 2'd0,
        PS_DOWN = 2'd1,
        PS_UP   = 2'd2
    } press_state_t;

    typedef enum logic [1:0] {
        PK_PLAIN  = 2'd0,
        PK_SERIES = 2'd1,
        PK_LONG   = 2'd2
    } press_kind_t;

    // Event attributes that travel beside the key code
    typedef struct packed {
        press_state_t          press;
        press_kind_t           kind;
        logic [TAP_WIDTH-1:0]  taps;
    } evt_info_t;

endpackage

// ===== rtl/kptl_tracker.sv =====
// ----------------------------------------------------------------------------
// kptl_tracker
// Press tracking state and the per-sample update that decides on an event.
// ----------------------------------------------------------------------------
module kptl_tracker #(
    parameter int KEY_WIDTH   = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  logic [KEY_WIDTH-1:0]             key,
    input  logic [KEY_WIDTH-1:0]             idle_code,
    input  logic [kptl_pkg::CFG_DATA_WIDTH-1:0] long_ticks,
    input  logic [kptl_pkg::CFG_DATA_WIDTH-1:0] gap_ticks,
    output logic                             emit,
    output logic [KEY_WIDTH-1:0]             evt_key,
    output kptl_pkg::evt_info_t              evt_info
);
    import kptl_pkg::*;

    localparam int EXT_WIDTH = TIMER_WIDTH + CFG_DATA_WIDTH;
    localparam logic [EXT_WIDTH-1:0] TIMER_MAX_EXT =
        {{CFG_DATA_WIDTH{1'b0}}, {TIMER_WIDTH{1'b1}}};

    logic [KEY_WIDTH-1:0]   cur_key_reg,  cur_key_next;
    logic [KEY_WIDTH-1:0]   prev_key_reg, prev_key_next;
    press_state_t           press_reg,    press_next;
    press_kind_t            kind_reg,     kind_next;
    logic [TAP_WIDTH-1:0]   taps_reg,     taps_next;
    logic [TIMER_WIDTH-1:0] hold_reg,     hold_next;
    logic [TIMER_WIDTH-1:0] gap_reg,      gap_next;

    logic [EXT_WIDTH-1:0]   long_ext, gap_ext;
    logic [TIMER_WIDTH-1:0] long_lim, gap_lim;

    // Clip limits that exceed the timer range to the largest timer value
    assign long_ext = {{TIMER_WIDTH{1'b0}}, long_ticks};
    assign gap_ext  = {{TIMER_WIDTH{1'b0}}, gap_ticks};
    assign long_lim = (long_ext > TIMER_MAX_EXT) ? {TIMER_WIDTH{1'b1}}
                                                 : long_ext[TIMER_WIDTH-1:0];
    assign gap_lim  = (gap_ext > TIMER_MAX_EXT)  ? {TIMER_WIDTH{1'b1}}
                                                 : gap_ext[TIMER_WIDTH-1:0];

    always_comb begin
        cur_key_next  = cur_key_reg;
        prev_key_next = prev_key_reg;
        press_next    = press_reg;
        kind_next     = kind_reg;
        taps_next     = taps_reg;
        hold_next     = hold_reg;
        gap_next      = gap_reg;
        emit          = 1'b0;
        if (key != idle_code) begin
            cur_key_next = key;
            if (prev_key_reg == key) begin
                if (press_reg == PS_DOWN) begin
                    if (hold_reg < long_lim) begin
                        hold_next = hold_reg + 1'b1;
                    end else if (kind_reg != PK_LONG) begin
                        kind_next = PK_LONG;
                        emit      = 1'b1;
                    end
                end else begin
                    // repeat tap within the gap
                    press_next = PS_DOWN;
                    kind_next  = PK_SERIES;
                    if (taps_reg != TAP_MAX) begin
                        taps_next = taps_reg + 1'b1;
                    end
                    gap_next = '0;
                    emit     = 1'b1;
                end
            end else begin
                press_next    = PS_DOWN;
                kind_next     = PK_PLAIN;
                taps_next     = '0;
                prev_key_next = key;
                gap_next      = '0;
                hold_next     = '0;
                emit          = 1'b1;
            end
        end else begin
            hold_next = '0;
            if (press_reg != PS_IDLE) begin
                if (gap_reg < gap_lim) begin
                    if (press_reg == PS_DOWN) begin
                        press_next = PS_UP;
                        emit       = 1'b1;
                    end
                    gap_next = gap_reg + 1'b1;
                end else begin
                    // gap expired: drop back to idle silently
                    press_next    = PS_IDLE;
                    kind_next     = PK_PLAIN;
                    taps_next     = '0;
                    cur_key_next  = idle_code;
                    prev_key_next = idle_code;
                end
            end
        end
    end

    always_comb begin
        evt_key        = cur_key_next;
        evt_info.press = press_next;
        evt_info.kind  = kind_next;
        evt_info.taps  = taps_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_key_reg  <= '0;
            prev_key_reg <= '0;
            press_reg    <= PS_IDLE;
            kind_reg     <= PK_PLAIN;
            taps_reg     <= '0;
            hold_reg     <= '0;
            gap_reg      <= '0;
        end else if (step) begin
            cur_key_reg  <= cur_key_next;
            prev_key_reg <= prev_key_next;
            press_reg    <= press_next;
            kind_reg     <= kind_next;
            taps_reg     <= taps_next;
            hold_reg     <= hold_next;
            gap_reg      <= gap_next;
        end
    end

endmodule

// ===== rtl/key_press_tap_long_detector.sv =====
// ----------------------------------------------------------------------------
// key_press_tap_long_detector
// Turns a stream of sampled key codes into press, tap, long-press and release
// events.
// ----------------------------------------------------------------------------
// Datapath: an accepted sample is held in the input register, processed by the
// tracker, and its event is registered in the output register behind m_tvalid.
// Throughput: one sample per cycle; a stalled event holds the input register
// once it has taken one more request.
// Reset: aresetn synchronous, active low; clears tracking state to idle and
// loads the register defaults (idle code 0, long press 100, tap gap 30).
// ----------------------------------------------------------------------------
module key_press_tap_long_detector #(
    parameter int KEY_WIDTH   = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: key_sample
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((KEY_WIDTH+7)/8)*8-1:0]        s_tdata,
    // m_tdata: event_key, event_press, event_taps
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((KEY_WIDTH+10+7)/8)*8-1:0]     m_tdata,
    // m_tuser: event_kind
    output logic [1:0]                            m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kptl_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [kptl_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import kptl_pkg::*;

    localparam int EVT_WIDTH = KEY_WIDTH + 10;
    localparam int OUT_WIDTH = ((EVT_WIDTH + 7) / 8) * 8;

    logic [KEY_WIDTH-1:0]      idle_code_reg;
    logic [CFG_DATA_WIDTH-1:0] long_ticks_reg;
    logic [CFG_DATA_WIDTH-1:0] gap_ticks_reg;
    logic [KEY_WIDTH+IDLE_CODE_WIDTH-1:0] idle_ext;

    logic                 in_valid_reg;
    logic [KEY_WIDTH-1:0] in_key_reg;
    logic                 advance;

    logic                 emit;
    logic [KEY_WIDTH-1:0] evt_key;
    evt_info_t            evt_info;

    logic                 out_valid_reg;
    logic [KEY_WIDTH-1:0] out_key_reg;
    evt_info_t            out_info_reg;

    assign cfg_ready = 1'b1;
    assign idle_ext  = {{KEY_WIDTH{1'b0}}, cfg_data[IDLE_CODE_WIDTH-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_code_reg  <= '0;
            long_ticks_reg <= LONG_TICKS_RESET;
            gap_ticks_reg  <= GAP_TICKS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IDLE_CODE:  idle_code_reg  <= idle_ext[KEY_WIDTH-1:0];
                CFG_LONG_TICKS: long_ticks_reg <= cfg_data;
                CFG_GAP_TICKS:  gap_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Process the held sample when the event register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_key_reg <= s_tdata[KEY_WIDTH-1:0];
        end
    end

    kptl_tracker #(
        .KEY_WIDTH   (KEY_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .key        (in_key_reg),
        .idle_code  (idle_code_reg),
        .long_ticks (long_ticks_reg),
        .gap_ticks  (gap_ticks_reg),
        .emit       (emit),
        .evt_key    (evt_key),
        .evt_info   (evt_info)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_key_reg  <= evt_key;
            out_info_reg <= evt_info;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_WIDTH'({out_info_reg.taps, out_info_reg.press, out_key_reg});
    assign m_tuser  = out_info_reg.kind;

endmodule
